@@ design/ufe_pkg.sv @@
// Package for the union-find engine: element and size types, index helpers,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package ufe_pkg;

  localparam int NumElements = 1024;
  localparam int IdxW        = $clog2(NumElements);
  localparam int OpW         = 10;
  localparam int SizeW       = 11;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [OpW-1:0]   op_t;
  typedef logic [SizeW-1:0] size_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic sel_b;
    logic fin_b;
    logic walk;
    logic halve;
    logic size_b;
    logic out_one;
    logic attach;
  } ufe_cmd_t;

  typedef struct packed {
    logic is_root;
    logic join_req;
    logic clr_last;
  } ufe_stat_t;

  // Element indices wrap modulo the table depth.
  function automatic idx_t wrap_idx(op_t op);
    logic [OpW+IdxW-1:0] w;
    w = {{IdxW{1'b0}}, op};
    return idx_t'(w % NumElements);
  endfunction

  function automatic op_t to_op(idx_t idx);
    logic [OpW+IdxW-1:0] w;
    w = {{OpW{1'b0}}, idx};
    return w[OpW-1:0];
  endfunction

endpackage

@@ design/union_find_engine.sv @@
// Union-find engine over a table of NumElements elements, path halving on
// every root walk. Top level; depends on ufe_pkg, ufe_ctrl and ufe_datapath.
//
// After reset the block runs a clearing pass over all NumElements (1024) entries
// with busy high. A transaction is taken when start is high and busy low.
// Each parent-chain step reads the single-read parent memory in turn
// (parent, then grandparent), and an item keeps busy high through both
// root walks and the size lookup, and through the attach step for a merge
// that joins two sets. The result appears on done_o for one cycle, in the
// cycle busy falls, and cannot be stalled.
module union_find_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic                 cmd_i,
  input  ufe_pkg::op_t         operand_a_i,
  input  ufe_pkg::op_t         operand_b_i,
  output logic                 done_o,
  output ufe_pkg::op_t         root_a_o,
  output ufe_pkg::op_t         root_b_o,
  output logic                 same_set_o,
  output logic                 merged_o,
  output ufe_pkg::size_t       set_size_o
);
  import ufe_pkg::*;

  ufe_cmd_t  cmd;
  ufe_stat_t stat;

  ufe_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  ufe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .merge_i     (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .root_a_o    (root_a_o),
    .root_b_o    (root_b_o),
    .same_set_o  (same_set_o),
    .merged_o    (merged_o),
    .set_size_o  (set_size_o),
    .done_o      (done_o)
  );

endmodule

@@ design/ufe_datapath.sv @@
// Datapath of the union-find engine: parent and size memories, walk
// registers and result registers. Depends on ufe_pkg.
module ufe_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ufe_pkg::ufe_cmd_t cmd_i,
  output ufe_pkg::ufe_stat_t stat_o,
  input  logic              merge_i,
  input  ufe_pkg::op_t      operand_a_i,
  input  ufe_pkg::op_t      operand_b_i,
  output ufe_pkg::op_t      root_a_o,
  output ufe_pkg::op_t      root_b_o,
  output logic              same_set_o,
  output logic              merged_o,
  output ufe_pkg::size_t    set_size_o,
  output logic              done_o
);
  import ufe_pkg::*;

  idx_t  parent_mem [NumElements];
  size_t size_mem   [NumElements];

  idx_t  par_rdata_q;
  size_t size_rdata_q;
  idx_t  clr_cnt_q, clr_cnt_d;
  logic  merge_q;
  idx_t  b_q, x_q, x_d, ra_q, rb_q;
  size_t sa_q;

  idx_t  par_raddr, par_waddr, par_wdata;
  logic  par_we;
  idx_t  size_raddr, size_waddr;
  size_t size_wdata, size_sum;
  logic  size_we;

  op_t   root_a_q, root_b_q;
  logic  same_q, merged_q, done_q;
  size_t set_size_q;

  assign size_sum = sa_q + size_rdata_q;

  always_comb begin
    par_raddr = x_q;
    if (cmd_i.load) begin
      par_raddr = wrap_idx(operand_a_i);
    end else if (cmd_i.sel_b) begin
      par_raddr = b_q;
    end else if (cmd_i.walk || cmd_i.halve) begin
      par_raddr = par_rdata_q;
    end

    par_we    = cmd_i.clr | cmd_i.halve | cmd_i.attach;
    par_waddr = clr_cnt_q;
    par_wdata = clr_cnt_q;
    if (cmd_i.halve) begin
      par_waddr = x_q;
      par_wdata = par_rdata_q;
    end else if (cmd_i.attach) begin
      par_waddr = rb_q;
      par_wdata = ra_q;
    end

    size_raddr = cmd_i.size_b ? rb_q : ra_q;
    if (cmd_i.fin_b) begin
      size_raddr = ra_q;
    end
    size_we    = cmd_i.clr | cmd_i.attach;
    size_waddr = cmd_i.attach ? ra_q : clr_cnt_q;
    size_wdata = cmd_i.attach ? size_sum : size_t'(1);

    x_d = x_q;
    if (cmd_i.load) begin
      x_d = wrap_idx(operand_a_i);
    end else if (cmd_i.sel_b) begin
      x_d = b_q;
    end else if (cmd_i.halve) begin
      x_d = par_rdata_q;
    end

    clr_cnt_d = cmd_i.clr ? clr_cnt_q + idx_t'(1) : clr_cnt_q;
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      parent_mem[par_waddr] <= par_wdata;
    end
    par_rdata_q <= parent_mem[par_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (size_we) begin
      size_mem[size_waddr] <= size_wdata;
    end
    size_rdata_q <= size_mem[size_raddr];
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    if (cmd_i.load) begin
      merge_q <= merge_i;
      b_q     <= wrap_idx(operand_b_i);
    end
    if (cmd_i.sel_b) begin
      ra_q <= x_q;
    end
    if (cmd_i.fin_b) begin
      rb_q <= x_q;
    end
    if (cmd_i.size_b) begin
      sa_q <= size_rdata_q;
    end
    if (cmd_i.out_one || cmd_i.attach) begin
      root_a_q   <= to_op(ra_q);
      root_b_q   <= to_op(rb_q);
      same_q     <= (ra_q == rb_q);
      merged_q   <= cmd_i.attach;
      set_size_q <= cmd_i.attach ? size_sum : size_rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
      done_q    <= cmd_i.out_one | cmd_i.attach;
    end
  end

  assign stat_o.is_root  = (par_rdata_q == x_q);
  assign stat_o.join_req = merge_q & (ra_q != rb_q);
  assign stat_o.clr_last = (clr_cnt_q == idx_t'(NumElements - 1));

  assign root_a_o   = root_a_q;
  assign root_b_o   = root_b_q;
  assign same_set_o = same_q;
  assign merged_o   = merged_q;
  assign set_size_o = set_size_q;
  assign done_o     = done_q;

endmodule

@@ design/ufe_ctrl.sv @@
// Controller of the union-find engine: sequences the clearing pass, the two
// root walks with path halving and the size update. Depends on ufe_pkg.
module ufe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  ufe_pkg::ufe_stat_t stat_i,
  output ufe_pkg::ufe_cmd_t  cmd_o
);
  import ufe_pkg::*;

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StChkP  = 3'd2;
  localparam logic [2:0] StChkG  = 3'd3;
  localparam logic [2:0] StSzA   = 3'd4;
  localparam logic [2:0] StSzB   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       phase_b_q, phase_b_d;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    phase_b_d = phase_b_q;
    case (state_q)
      StClear: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          phase_b_d  = 1'b0;
          state_d    = StChkP;
        end
      end
      StChkP: begin
        if (!stat_i.is_root) begin
          cmd_o.walk = 1'b1;
          state_d    = StChkG;
        end else if (!phase_b_q) begin
          cmd_o.sel_b = 1'b1;
          phase_b_d   = 1'b1;
        end else begin
          cmd_o.fin_b = 1'b1;
          state_d     = StSzA;
        end
      end
      StChkG: begin
        cmd_o.halve = 1'b1;
        state_d     = StChkP;
      end
      StSzA: begin
        cmd_o.size_b = 1'b1;
        if (stat_i.join_req) begin
          state_d = StSzB;
        end else begin
          cmd_o.out_one = 1'b1;
          state_d       = StIdle;
        end
      end
      StSzB: begin
        cmd_o.attach = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StClear;
      phase_b_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_b_q <= phase_b_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

@@ design/ufe_checker.sv @@
// Port-level checker for the union-find engine and its bind to the top level.
// Depends on ufe_pkg and union_find_engine.
module ufe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input ufe_pkg::op_t   root_a_o,
  input ufe_pkg::op_t   root_b_o,
  input logic           same_set_o,
  input logic           merged_o,
  input ufe_pkg::size_t set_size_o
);
  import ufe_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  a_merge_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && merged_o) |-> (!same_set_o && set_size_o != size_t'(0)))
    else $error("merge reported for one set");

  a_same_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && same_set_o) |-> (root_a_o == root_b_o))
    else $error("same set reported with different roots");

endmodule

bind union_find_engine ufe_checker u_ufe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .root_a_o   (root_a_o),
  .root_b_o   (root_b_o),
  .same_set_o (same_set_o),
  .merged_o   (merged_o),
  .set_size_o (set_size_o)
);

@@ tb/union_find_checker.sv @@
`timescale 1ns / 1ps
// Command codes shared by the union-find testbench, and the checker that
// tracks its own disjoint-set tables and compares every result with them.
// Depends on ufe_pkg.
package uf_tb_pkg;

  typedef enum logic {
    CmdQuery = 1'b0,
    CmdMerge = 1'b1
  } uf_cmd_e;

endpackage

module union_find_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 cmd_i,
  input  ufe_pkg::op_t         operand_a_i,
  input  ufe_pkg::op_t         operand_b_i,
  input  logic                 done_i,
  input  ufe_pkg::op_t         root_a_i,
  input  ufe_pkg::op_t         root_b_i,
  input  logic                 same_set_i,
  input  logic                 merged_i,
  input  ufe_pkg::size_t       set_size_i,
  output int                   err_count_o,
  output int                   pending_o
);

  import ufe_pkg::*;
  import uf_tb_pkg::*;

  typedef struct packed {
    op_t   root_a;
    op_t   root_b;
    logic  same_set;
    logic  merged;
    size_t set_size;
  } uf_result_t;

  idx_t       parent_tab [NumElements];
  size_t      size_tab   [NumElements];
  uf_result_t results_due[$];

  // Walks to the root and points every visited entry at its grandparent.
  function automatic idx_t find_root(idx_t x);
    idx_t up;
    int   steps;
    steps = 0;
    while (x != parent_tab[x] && steps < NumElements) begin
      up            = parent_tab[x];
      parent_tab[x] = parent_tab[up];
      x             = parent_tab[x];
      steps++;
    end
    return x;
  endfunction

  function automatic uf_result_t apply_command(uf_cmd_e cmd, op_t a, op_t b);
    idx_t       ra;
    idx_t       rb;
    uf_result_t r;
    ra         = find_root(idx_t'(a % NumElements));
    rb         = find_root(idx_t'(b % NumElements));
    r.same_set = (ra == rb);
    r.merged   = (cmd == CmdMerge) && !r.same_set;
    if (r.merged) begin
      size_tab[ra]   = size_tab[ra] + size_tab[rb];
      parent_tab[rb] = ra;
    end
    r.root_a   = op_t'(ra);
    r.root_b   = op_t'(rb);
    r.set_size = size_tab[ra];
    return r;
  endfunction

  task automatic check_field(string field, int expected, int actual);
    if (expected != actual) begin
      $error("%s mismatch: expected %0d, actual %0d", field, expected, actual);
      err_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    uf_result_t exp_r;
    uf_result_t new_r;
    if (!rst_ni) begin
      for (int i = 0; i < NumElements; i++) begin
        parent_tab[i] = idx_t'(i);
        size_tab[i]   = size_t'(1);
      end
      results_due.delete();
      err_count_o = 0;
      pending_o  <= 0;
    end else begin
      if (done_i) begin
        if (results_due.size() == 0) begin
          $error("Result transaction arrived with no expectation waiting.");
          err_count_o++;
        end else begin
          exp_r = results_due.pop_front();
          check_field("root_a", exp_r.root_a, root_a_i);
          check_field("root_b", exp_r.root_b, root_b_i);
          check_field("same_set", exp_r.same_set, same_set_i);
          check_field("merged", exp_r.merged, merged_i);
          check_field("set_size", exp_r.set_size, set_size_i);
        end
      end
      if (start_i && !busy_i) begin
        new_r       = apply_command(uf_cmd_e'(cmd_i), operand_a_i, operand_b_i);
        results_due = {results_due, new_r};
      end
      pending_o <= results_due.size();
    end
  end

endmodule

@@ tb/tb_union_find_engine.sv @@
`timescale 1ns / 1ps
// Testbench top for union_find_engine: drives directed and random query and
// merge transactions and gives the verdict. Depends on ufe_pkg and union_find_checker.
module tb_union_find_engine;

  import ufe_pkg::*;
  import uf_tb_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int PhaseItems = 643;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  logic  cmd_i;
  op_t   operand_a_i;
  op_t   operand_b_i;
  logic  done_o;
  op_t   root_a_o;
  op_t   root_b_o;
  logic  same_set_o;
  logic  merged_o;
  size_t set_size_o;
  int    err_count;
  int    pending;
  int    cycle_count;
  op_t   cluster_base;

  union_find_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .done_o      (done_o),
    .root_a_o    (root_a_o),
    .root_b_o    (root_b_o),
    .same_set_o  (same_set_o),
    .merged_o    (merged_o),
    .set_size_o  (set_size_o)
  );

  union_find_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .cmd_i       (cmd_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .done_i      (done_o),
    .root_a_i    (root_a_o),
    .root_b_i    (root_b_o),
    .same_set_i  (same_set_o),
    .merged_i    (merged_o),
    .set_size_i  (set_size_o),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL union_find_engine");
      $finish;
    end
  end

  task automatic send_command(uf_cmd_e cmd, op_t a, op_t b, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start       <= 1'b1;
    cmd_i       <= cmd;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Half the picks come from a small moving window so that deep chains form.
  function automatic op_t pick_element();
    if ($urandom_range(1)) return op_t'($urandom_range(1023));
    return cluster_base + op_t'($urandom_range(15));
  endfunction

  task automatic run_random_phase(int idle_pct);
    op_t     a;
    op_t     b;
    uf_cmd_e cmd;
    for (int n = 0; n < PhaseItems; n++) begin
      if (n % 64 == 0) cluster_base = op_t'($urandom_range(1023));
      a   = pick_element();
      b   = ($urandom_range(15) == 0) ? a : pick_element();
      cmd = ($urandom_range(99) < 60) ? CmdMerge : CmdQuery;
      send_command(cmd, a, b, idle_pct);
    end
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    cmd_i        = CmdQuery;
    operand_a_i  = '0;
    operand_b_i  = '0;
    cycle_count  = 0;
    cluster_base = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_command(CmdQuery, 10'd0, 10'd0, 0);
    send_command(CmdQuery, 10'd1023, 10'd1023, 0);
    send_command(CmdMerge, 10'd0, 10'd1023, 0);
    send_command(CmdMerge, 10'd1023, 10'd0, 0);
    send_command(CmdQuery, 10'd1023, 10'd0, 0);
    send_command(CmdMerge, 10'd682, 10'd341, 0);
    send_command(CmdMerge, 10'd5, 10'd5, 0);
    for (int i = 10; i < 16; i++) begin
      send_command(CmdMerge, op_t'(i + 1), op_t'(i), 0);
    end
    send_command(CmdQuery, 10'd10, 10'd10, 0);
    send_command(CmdQuery, 10'd10, 10'd13, 0);
    send_command(CmdMerge, 10'd0, 10'd10, 0);
    send_command(CmdMerge, 10'd16, 10'd1023, 0);
    send_command(CmdQuery, 10'd1022, 10'd1, 0);
    send_command(CmdMerge, 10'd512, 10'd511, 0);
    send_command(CmdMerge, 10'd341, 10'd16, 0);
    wait_all_results();

    run_random_phase(10);
    wait_all_results();
    run_random_phase(76);
    wait_all_results();
    run_random_phase(0);
    wait_all_results();
    repeat (20) @(posedge clk_i);

    if (err_count == 0 && pending == 0) begin
      $display("PASS union_find_engine");
    end else begin
      $display("FAIL union_find_engine");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ufe_pkg.sv
design/ufe_datapath.sv
design/ufe_ctrl.sv
design/union_find_engine.sv
design/ufe_checker.sv
tb/union_find_checker.sv
tb/tb_union_find_engine.sv
